// ----- design/sct_pkg.sv -----
// Shared types and fixed constants for the Taylor-series sine/cosine unit.
// Holds the beat structs, the sequencer state type and the multiply/divide request.
// No dependencies.
package sct_pkg;

  localparam int unsigned ANGLE_FRAC = 28;
  localparam int unsigned VALUE_W    = 30;
  localparam int unsigned TERMS_W    = 6;
  localparam int unsigned TOL_W      = 8;

  localparam logic signed [31:0] ANGLE_LIMIT = 32'sd1686629713;
  localparam logic [63:0]        PI_HALF_Q40 = 64'd1727108826179;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] angle;
  } sct_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TERMS_W-1:0]        terms_used;
  } sct_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_ARG,
    ST_ABS,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_ACC,
    ST_SIGN,
    ST_CLAMP,
    ST_OUT
  } sct_state_e;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } sct_op_e;

  typedef struct packed {
    logic    start;
    sct_op_e op;
  } sct_mdu_req_t;

endpackage

// ----- design/sct_mdu.sv -----
// Shared iterative multiply/divide unit of the sine/cosine unit.
// Multiply: 16-bit chunks per cycle, result scaled down by FRAC_BITS; divide: radix 4.
// Depends on sct_pkg.
module sct_mdu import sct_pkg::*; #(
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sct_mdu_req_t                       req_i,
  input  logic [FRAC_BITS+8:0]               op_a_i,
  input  logic [FRAC_BITS+2:0]               op_b_i,
  input  logic [$clog2(MAX_TERMS+1):0]       div_i,
  output logic                               done_o,
  output logic [FRAC_BITS+11:0]              res_o
);

  localparam int unsigned AW   = FRAC_BITS + 3;
  localparam int unsigned TW   = FRAC_BITS + 9;
  localparam int unsigned MW   = FRAC_BITS + 12;
  localparam int unsigned DW   = $clog2(MAX_TERMS + 1) + 1;
  localparam int unsigned CW   = 16;
  localparam int unsigned NC   = (AW + CW - 1) / CW;
  localparam int unsigned BPW  = NC * CW;
  localparam int unsigned PW   = TW + BPW;
  localparam int unsigned QB   = MW + (MW % 2);
  localparam int unsigned ST   = QB / 2;
  localparam int unsigned CNTW = $clog2(ST);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  sct_op_e         op_q, op_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [TW-1:0]   opa_q, opa_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [QB-1:0]   quo_q, quo_d;
  logic [DW-1:0]   d1_q, d1_d;
  logic [DW:0]     d2_q, d2_d;
  logic [DW+1:0]   d3_q, d3_d;
  logic [MW-1:0]   res_q, res_d;

  logic [BPW-1:0]   bpad;
  logic [CW-1:0]    chunk;
  logic [TW+CW-1:0] prod;
  logic [PW-1:0]    acc_nx;
  logic [DW+1:0]    r4;
  logic [DW+1:0]    rdiff;
  logic [1:0]       qd;
  logic [QB-1:0]    quo_nx;

  assign bpad   = BPW'(op_b_i);
  assign chunk  = CW'(bpad >> (cnt_q * CW));
  assign prod   = opa_q * chunk;
  assign acc_nx = (acc_q << CW) + PW'(prod);
  assign r4     = {rem_q, quo_q[QB-1 -: 2]};

  always_comb begin
    if (r4 >= d3_q) begin
      qd    = 2'd3;
      rdiff = r4 - d3_q;
    end else if (r4 >= (DW+2)'(d2_q)) begin
      qd    = 2'd2;
      rdiff = r4 - (DW+2)'(d2_q);
    end else if (r4 >= (DW+2)'(d1_q)) begin
      qd    = 2'd1;
      rdiff = r4 - (DW+2)'(d1_q);
    end else begin
      qd    = 2'd0;
      rdiff = r4;
    end
  end

  assign quo_nx = {quo_q[QB-3:0], qd};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    opa_d  = opa_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    d1_d   = d1_q;
    d2_d   = d2_q;
    d3_d   = d3_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      if (req_i.op == MDU_MUL) begin
        cnt_d = CNTW'(NC - 1);
        acc_d = '0;
        opa_d = op_a_i;
      end else begin
        cnt_d = CNTW'(ST - 1);
        rem_d = '0;
        quo_d = QB'(res_q);
        d1_d  = div_i;
        d2_d  = {div_i, 1'b0};
        d3_d  = (DW+2)'(div_i) + (DW+2)'({div_i, 1'b0});
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (op_q == MDU_MUL) begin
        acc_d = acc_nx;
      end else begin
        rem_d = rdiff[DW-1:0];
        quo_d = quo_nx;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = (op_q == MDU_MUL) ? acc_nx[FRAC_BITS +: MW] : quo_nx[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= MDU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    d3_q  <= d3_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- design/sine_cosine_taylor_series_unit.sv -----
// Top level of the Taylor-series sine/cosine unit: sequencer, argument and result stages.
// Depends on sct_pkg and sct_mdu.
//
// Usage: an input beat carries kind (0 sine, 1 cosine) and a signed Q3.28 angle; the
// result beat carries a signed Q1.28 value and the count of terms added after the first.
// Both channels use valid/ready. One beat is worked on at a time: in_ready_o is high
// only while the sequencer is idle. The result sits in an output register, so a new
// beat is taken while the previous result still waits; the sequencer holds at its last
// step only if that register is still full when the next result is done.
// Each term takes two multiplies, done in 16-bit chunks of the argument magnitude, and
// two radix-4 divides, all on the single shared multiply/divide unit; a new beat is
// taken only once the previous one has left the sequencer.
// term_tolerance is written through cfg_we_i/cfg_wdata_i, only while idle; the user
// must keep to this, as the block itself does not enforce it.
// Reset clears the sequencer, the output valid and the tolerance (to 0); no clearing
// pass is needed. A stalled receiver holds the result beat unchanged until taken.
module sine_cosine_taylor_series_unit import sct_pkg::*; #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sct_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sct_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW     = FRAC_BITS + 3;
  localparam int unsigned XW     = FRAC_BITS + 5;
  localparam int unsigned TW     = FRAC_BITS + 9;
  localparam int unsigned MW     = FRAC_BITS + 12;
  localparam int unsigned SW     = FRAC_BITS + 12;
  localparam int unsigned NW     = $clog2(MAX_TERMS + 1);
  localparam int unsigned DW     = NW + 1;
  localparam int unsigned UP_SH  = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
  localparam int unsigned DN_SH  = (FRAC_BITS < ANGLE_FRAC) ? ANGLE_FRAC - FRAC_BITS : 0;
  localparam int unsigned PH_SH  = 40 - FRAC_BITS;
  localparam int unsigned PH_RND = (PH_SH > 0) ? PH_SH - 1 : 0;
  localparam logic [63:0] PI_HALF = (PH_SH == 0) ? PI_HALF_Q40 :
                                    ((PI_HALF_Q40 + (64'd1 << PH_RND)) >> PH_SH);

  sct_state_e state_q, state_d;
  logic launched_q, launched_d;
  logic out_valid_q, out_valid_d;
  logic [TOL_W-1:0] tol_q;

  logic                     kind_q, kind_d;
  logic signed [31:0]       ang_q, ang_d;
  logic                     aneg_q, aneg_d;
  logic [30:0]              mag_q, mag_d;
  logic signed [XW-1:0]     x_q, x_d;
  logic                     neg_q, neg_d;
  logic [AW-1:0]            ax_q, ax_d;
  logic [TW-1:0]            t_q, t_d;
  logic [NW-1:0]            n_q, n_d;
  logic signed [SW-1:0]     sum_q, sum_d;
  logic                     fsgn_q, fsgn_d;
  logic [FRAC_BITS:0]       fmag_q, fmag_d;
  sct_out_t                 out_q, out_d;

  sct_mdu_req_t     mdu_req;
  logic             mdu_done;
  logic [MW-1:0]    mdu_res;
  logic [DW-1:0]    mdu_div;

  logic signed [31:0]   ang_sat;
  logic [63:0]          mag_wide;
  logic [63:0]          tol_wide;
  logic [63:0]          q28_wide;
  logic [AW-1:0]        mag_int;
  logic [TW-1:0]        tol_int;
  logic signed [XW-1:0] ph_x;
  logic signed [XW-1:0] m_x;
  logic signed [XW-1:0] abs_x;
  logic signed [SW-1:0] t_ext;
  logic signed [SW-1:0] one_s;
  logic signed [SW-1:0] abs_s;
  logic [VALUE_W-1:0]   q30;
  logic                 term_exit;

  assign ang_sat  = (in_data_i.angle > ANGLE_LIMIT)  ? ANGLE_LIMIT :
                    (in_data_i.angle < -ANGLE_LIMIT) ? -ANGLE_LIMIT : in_data_i.angle;
  assign mag_wide = (64'(mag_q) << UP_SH) >> DN_SH;
  assign tol_wide = (64'(tol_q) << UP_SH) >> DN_SH;
  assign q28_wide = (64'(fmag_q) << DN_SH) >> UP_SH;
  assign mag_int  = mag_wide[AW-1:0];
  assign tol_int  = tol_wide[TW-1:0];
  assign ph_x     = $signed(PI_HALF[XW-1:0]);
  assign m_x      = $signed(XW'(mag_int));
  assign abs_x    = x_q[XW-1] ? -x_q : x_q;
  assign t_ext    = $signed(SW'(t_q));
  assign one_s    = $signed(SW'(1) << FRAC_BITS);
  assign abs_s    = sum_q[SW-1] ? -sum_q : sum_q;
  assign q30      = q28_wide[VALUE_W-1:0];
  assign term_exit = (t_q <= tol_int) || (n_q == NW'(MAX_TERMS));
  assign mdu_div  = {n_q, (state_q == ST_DIV2)};

  always_comb begin
    state_d     = state_q;
    launched_d  = launched_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    ang_d       = ang_q;
    aneg_d      = aneg_q;
    mag_d       = mag_q;
    x_d         = x_q;
    neg_d       = neg_q;
    ax_d        = ax_q;
    t_d         = t_q;
    n_d         = n_q;
    sum_d       = sum_q;
    fsgn_d      = fsgn_q;
    fmag_d      = fmag_q;
    out_d       = out_q;
    mdu_req     = '{start: 1'b0, op: MDU_MUL};
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          ang_d   = ang_sat;
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        aneg_d  = ang_q[31];
        mag_d   = ang_q[31] ? 31'(-ang_q) : ang_q[30:0];
        state_d = ST_ARG;
      end
      ST_ARG: begin
        if (kind_q) begin
          x_d = aneg_q ? ph_x + m_x : ph_x - m_x;
        end else begin
          x_d = aneg_q ? -m_x : m_x;
        end
        state_d = ST_ABS;
      end
      ST_ABS: begin
        neg_d   = x_q[XW-1];
        ax_d    = abs_x[AW-1:0];
        t_d     = TW'(abs_x[AW-1:0]);
        sum_d   = $signed(SW'(abs_x[AW-1:0]));
        n_d     = NW'(1);
        state_d = ST_MUL1;
      end
      ST_MUL1, ST_MUL2, ST_DIV1, ST_DIV2: begin
        mdu_req.start = !launched_q;
        mdu_req.op    = (state_q == ST_DIV1 || state_q == ST_DIV2) ? MDU_DIV : MDU_MUL;
        launched_d    = 1'b1;
        if (mdu_done) begin
          launched_d = 1'b0;
          case (state_q)
            ST_MUL1: state_d = ST_DIV1;
            ST_DIV1: begin
              t_d     = mdu_res[TW-1:0];
              state_d = ST_MUL2;
            end
            ST_MUL2: state_d = ST_DIV2;
            default: begin
              t_d     = mdu_res[TW-1:0];
              state_d = ST_ACC;
            end
          endcase
        end
      end
      ST_ACC: begin
        sum_d = n_q[0] ? sum_q - t_ext : sum_q + t_ext;
        if (term_exit) begin
          state_d = ST_SIGN;
        end else begin
          n_d     = n_q + 1'b1;
          state_d = ST_MUL1;
        end
      end
      ST_SIGN: begin
        sum_d   = neg_q ? -sum_q : sum_q;
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (sum_q > one_s) begin
          fsgn_d = 1'b0;
          fmag_d = one_s[FRAC_BITS:0];
        end else if (sum_q < -one_s) begin
          fsgn_d = 1'b1;
          fmag_d = one_s[FRAC_BITS:0];
        end else begin
          fsgn_d = sum_q[SW-1];
          fmag_d = abs_s[FRAC_BITS:0];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.value      = fsgn_q ? -$signed(q30) : $signed(q30);
          out_d.terms_used = TERMS_W'(n_q);
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tol_q       <= '0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ang_q  <= ang_d;
    aneg_q <= aneg_d;
    mag_q  <= mag_d;
    x_q    <= x_d;
    neg_q  <= neg_d;
    ax_q   <= ax_d;
    t_q    <= t_d;
    n_q    <= n_d;
    sum_q  <= sum_d;
    fsgn_q <= fsgn_d;
    fmag_q <= fmag_d;
    out_q  <= out_d;
  end

  sct_mdu #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_TERMS (MAX_TERMS)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .op_a_i (t_q),
    .op_b_i (ax_q),
    .div_i  (mdu_div),
    .done_o (mdu_done),
    .res_o  (mdu_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
